>>> hw/rtl/psht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psht_pkg
// shared types and constants for the sorted priority handler table
// ----------------------------------------------------------------------------
package psht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic       OP_REGISTER = 1'b0;
  localparam logic       OP_DISPATCH = 1'b1;
  localparam logic [3:0] EV_WILDCARD = 4'd0;

  typedef enum logic [1:0] {
    ST_REGISTERED = 2'd0,
    ST_MATCH      = 2'd1,
    ST_NO_MATCH   = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef struct packed {
    logic              opcode;
    logic signed [15:0] priority_req;
    logic [3:0]        event_code;
    logic [7:0]        handler_id;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] match_id;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic [3:0]         ev_code;
    logic [7:0]         handler;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic prio_gt;
    logic ev_match;
  } cmp_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/priority_sorted_handler_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_sorted_handler_table_unit
// handler table kept in ascending priority order, register and dispatch
// ----------------------------------------------------------------------------
// register: each entry with a higher priority is shifted up one slot (read
//   then write through the single table ram), then the new entry is compared
//   and lands beside a lower or equal entry, or lands in slot zero; a full
//   table answers with a full status and nothing changes
// dispatch: scans the entries in order, one ram read per cycle, one result per
//   match; empty table answers no match; results are a strobe the receiver cannot stall
// reset clears the entry count and control state; table contents need no clearing pass
// ----------------------------------------------------------------------------
module priority_sorted_handler_table_unit
  import psht_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd,
  output logic      rsp_valid,
  output rsp_t      rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,   // read the entry just below the hole
    S_INS_CMP,  // shift it up or drop the new entry into the hole
    S_INS_PUT,  // hole reached slot zero
    S_DSP,      // scan entries in order
    S_DSP_FIN   // flush the held match or report no match
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;       // number of valid entries
  logic [CNT_W-1:0] pos;       // hole position on insert, scan index on dispatch
  logic [CNT_W-1:0] pos_m1;
  cmd_t             item;      // transaction being worked on
  logic             rd_pend;   // ram read data is valid this cycle
  logic             held_valid;
  logic [7:0]       held_id;   // last match, kept back until we know if it is final

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_entry;
  entry_t           new_entry;
  cmp_res_t         cmp;

  assign pos_m1    = pos - 1'b1;
  assign rd_entry  = entry_t'(ram_rdata);
  assign busy      = (state != S_IDLE);

  always_comb begin
    new_entry.prio    = item.priority_req;
    new_entry.ev_code = item.event_code;
    new_entry.handler = item.handler_id;
  end

  psht_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // one comparator serves both insertion ordering and dispatch matching
  psht_cmp u_cmp (
    .entry(rd_entry),
    .item (item),
    .res  (cmp)
  );

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos[IDX_W-1:0];
    ram_wdata = new_entry;
    ram_raddr = pos_m1[IDX_W-1:0];
    case (state)
      S_INS_CMP: begin
        ram_we = 1'b1;
        // a higher entry moves up into the hole, otherwise the new one lands
        ram_wdata = cmp.prio_gt ? ram_rdata : ENTRY_W'(new_entry);
      end
      S_INS_PUT: begin
        ram_we = 1'b1;
      end
      S_DSP: begin
        ram_raddr = pos[IDX_W-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      rd_pend    <= 1'b0;
      held_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            item <= cmd;
            if (cmd.opcode == OP_REGISTER) begin
              if (cnt == CNT_W'(TABLE_DEPTH)) begin
                // table full: nothing changes
                rsp_valid    <= 1'b1;
                rsp.status   <= ST_FULL;
                rsp.match_id <= '0;
                rsp.last     <= 1'b1;
              end else begin
                pos   <= cnt;
                state <= (cnt == '0) ? S_INS_PUT : S_INS_RD;
              end
            end else begin
              pos        <= '0;
              rd_pend    <= 1'b0;
              held_valid <= 1'b0;
              if (cnt == '0) begin
                rsp_valid    <= 1'b1;
                rsp.status   <= ST_NO_MATCH;
                rsp.match_id <= '0;
                rsp.last     <= 1'b1;
              end else begin
                state <= S_DSP;
              end
            end
          end
        end
        S_INS_RD: begin
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (cmp.prio_gt) begin
            pos   <= pos_m1;
            state <= (pos_m1 == '0) ? S_INS_PUT : S_INS_RD;
          end else begin
            cnt          <= cnt + 1'b1;
            rsp_valid    <= 1'b1;
            rsp.status   <= ST_REGISTERED;
            rsp.match_id <= '0;
            rsp.last     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_INS_PUT: begin
          cnt          <= cnt + 1'b1;
          rsp_valid    <= 1'b1;
          rsp.status   <= ST_REGISTERED;
          rsp.match_id <= '0;
          rsp.last     <= 1'b1;
          state        <= S_IDLE;
        end
        S_DSP: begin
          // issue the next read while judging the previous one
          if (pos < cnt) begin
            pos     <= pos + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state   <= S_DSP_FIN;
          end
          if (rd_pend && cmp.ev_match) begin
            if (held_valid) begin
              rsp_valid    <= 1'b1;
              rsp.status   <= ST_MATCH;
              rsp.match_id <= held_id;
              rsp.last     <= 1'b0;
            end
            held_id    <= rd_entry.handler;
            held_valid <= 1'b1;
          end
        end
        S_DSP_FIN: begin
          rsp_valid <= 1'b1;
          rsp.last  <= 1'b1;
          if (held_valid) begin
            rsp.status   <= ST_MATCH;
            rsp.match_id <= held_id;
          end else begin
            rsp.status   <= ST_NO_MATCH;
            rsp.match_id <= '0;
          end
          held_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/psht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psht_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module psht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/psht_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psht_cmp
// shared compare unit: priority order and event match of one table entry
// ----------------------------------------------------------------------------
module psht_cmp
  import psht_pkg::*;
(
  input  wire entry_t   entry,
  input  wire cmd_t     item,
  output cmp_res_t      res
);

  always_comb begin
    res.prio_gt  = $signed(entry.prio) > $signed(item.priority_req);
    res.ev_match = (entry.ev_code == EV_WILDCARD) || (entry.ev_code == item.event_code);
  end

endmodule
`default_nettype wire
